/* hw/rtl/htp_pkg.sv */
// ----------------------------------------------------------------------------
// Hex tile placement package
// Shared widths, codes, control structs and the hash residue step.
// ----------------------------------------------------------------------------
package htp_pkg;

  localparam int unsigned MAX_TILES_DEF = 1024;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NUM_DIGITS = HASH_W / DIGIT_W;
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS);
  localparam int unsigned NUM_EDGES  = 6;
  localparam int unsigned EDGE_W     = 3;

  localparam logic [HASH_W-1:0] HASH_MUL = HASH_W'(33);

  localparam logic STATUS_PLACED = 1'b0;
  localparam logic STATUS_FULL   = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYTE  = 2'd0,
    MODE_PLACE = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [EDGE_W-1:0] {
    EDGE_E    = 3'd0,
    EDGE_NE   = 3'd1,
    EDGE_NW   = 3'd2,
    EDGE_WEST = 3'd3,
    EDGE_SW   = 3'd4,
    EDGE_SE   = 3'd5
  } edge_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PRD,
    ST_PLD,
    ST_CAND,
    ST_SCAN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic mod_step;
    logic par_rd;
    logic par_ld;
    logic cand_ld;
    logic scan;
    logic next_edge;
    logic next_par;
    logic set_fail;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic mod_last;
    logic hit;
    logic free;
    logic edge_last;
    logic par_zero;
    logic out_free;
  } sts_t;

  // One digit of the residue of a 32-bit value modulo six, most significant first.
  function automatic logic [EDGE_W-1:0] mod6_step(input logic [EDGE_W-1:0] r,
                                                   input logic [DIGIT_W-1:0] nib);
    logic [6:0] v;
    v = {r, 4'b0000} + 7'(nib);
    if (v >= 7'd48) v = v - 7'd48;
    if (v >= 7'd24) v = v - 7'd24;
    if (v >= 7'd12) v = v - 7'd12;
    if (v >= 7'd6)  v = v - 7'd6;
    return v[EDGE_W-1:0];
  endfunction

endpackage

/* hw/rtl/htp_in_if.sv */
// ----------------------------------------------------------------------------
// Hex tile placement input channel
// Valid/ready channel carrying one mode and one name byte per request.
// ----------------------------------------------------------------------------
interface htp_in_if;
  import htp_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] name_byte;

  modport source (output valid, mode, name_byte, input ready);
  modport sink   (input valid, mode, name_byte, output ready);
endinterface

/* hw/rtl/htp_out_if.sv */
// ----------------------------------------------------------------------------
// Hex tile placement output channel
// Valid/ready channel carrying one placement result per place request.
// ----------------------------------------------------------------------------
interface htp_out_if;
  import htp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [INDEX_W-1:0]        tile_index;
  logic signed [COORD_W-1:0] tile_x;
  logic signed [COORD_W-1:0] tile_y;
  logic                      status;

  modport source (output valid, tile_index, tile_x, tile_y, status, input ready);
  modport sink   (input valid, tile_index, tile_x, tile_y, status, output ready);
endinterface

/* hw/rtl/htp_datapath.sv */
// ----------------------------------------------------------------------------
// Hex tile placement datapath
// Hash, tile store, neighbor generation, occupancy scan and result register.
// ----------------------------------------------------------------------------
module htp_datapath #(
  parameter int unsigned MAX_TILES = htp_pkg::MAX_TILES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  htp_pkg::cmd_t                     cmd_i,
  output htp_pkg::sts_t                     sts_o,
  input  logic [htp_pkg::MODE_W-1:0]        mode_i,
  input  logic [htp_pkg::BYTE_W-1:0]        name_byte_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [htp_pkg::INDEX_W-1:0]       tile_index_o,
  output logic signed [htp_pkg::COORD_W-1:0] tile_x_o,
  output logic signed [htp_pkg::COORD_W-1:0] tile_y_o,
  output logic                              status_o
);
  import htp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_TILES);
  localparam int unsigned CNT_W = $clog2(MAX_TILES + 1);
  localparam int unsigned CW    = IDX_W + 2;

  logic [2*CW-1:0]    mem [MAX_TILES];
  logic [2*CW-1:0]    rd_q;
  logic               rd_vld_q;
  logic [HASH_W-1:0]  hash_q;
  logic [HASH_W-1:0]  h_q;
  logic [HASH_W-1:0]  esum_q;
  logic [EDGE_W-1:0]  hmod_q;
  logic [EDGE_W-1:0]  eres_q;
  logic [EDGE_W-1:0]  ecnt_q;
  logic [DIG_CNT_W-1:0] dig_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   scan_q;
  logic [IDX_W-1:0]   par_q;
  logic [CW-1:0]      px_q, py_q, cx_q, cy_q;
  logic [CW-1:0]      nx, ny;
  logic               fail_q;
  logic               out_valid_q;
  logic [INDEX_W-1:0] idx_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic               status_q;

  logic               take_byte, take_place, take_clear;
  logic               hit, scan_end, issue, rd_en, wr_en, out_free;
  logic [IDX_W-1:0]   rd_addr;
  logic [DIG_CNT_W-1:0] dsel;
  logic [DIGIT_W-1:0] nib;
  logic [CNT_W+INDEX_W-1:0] cnt_ext;
  logic [CW+COORD_W-1:0]    cx_ext, cy_ext;

  assign take_byte  = cmd_i.take && (mode_i == MODE_BYTE) && (name_byte_i != '0);
  assign take_place = cmd_i.take && (mode_i == MODE_PLACE);
  assign take_clear = cmd_i.take && (mode_i == MODE_CLEAR);

  assign dsel = DIG_CNT_W'(NUM_DIGITS - 1) - dig_q;
  assign nib  = h_q[{dsel, 2'b00} +: DIGIT_W];

  always_comb begin
    nx = px_q;
    ny = py_q;
    case (edge_e'(eres_q))
      EDGE_E: begin
        nx = px_q + CW'(1);
      end
      EDGE_NE: begin
        nx = py_q[0] ? px_q + CW'(1) : px_q;
        ny = py_q - CW'(1);
      end
      EDGE_NW: begin
        nx = py_q[0] ? px_q : px_q - CW'(1);
        ny = py_q - CW'(1);
      end
      EDGE_WEST: begin
        nx = px_q - CW'(1);
      end
      EDGE_SW: begin
        nx = py_q[0] ? px_q : px_q - CW'(1);
        ny = py_q + CW'(1);
      end
      default: begin
        nx = py_q[0] ? px_q + CW'(1) : px_q;
        ny = py_q + CW'(1);
      end
    endcase
  end

  assign hit      = rd_vld_q && (rd_q == {cx_q, cy_q});
  assign scan_end = (scan_q == cnt_q);
  assign issue    = cmd_i.scan && !scan_end && !hit;
  assign rd_en    = cmd_i.par_rd || issue;
  assign rd_addr  = cmd_i.par_rd ? par_q : scan_q[IDX_W-1:0];
  assign wr_en    = cmd_i.finish && !fail_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= {cx_q, cy_q};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (take_byte) begin
        hash_q <= HASH_W'(hash_q * HASH_MUL) + HASH_W'(name_byte_i);
      end else if (take_place || take_clear) begin
        hash_q <= '0;
      end
      if (take_clear) begin
        cnt_q <= '0;
      end else if (wr_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (take_place) begin
        fail_q <= (cnt_q == CNT_W'(MAX_TILES));
      end else if (cmd_i.set_fail) begin
        fail_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cnt_ext = {{INDEX_W{1'b0}}, cnt_q};
  assign cx_ext  = {{COORD_W{cx_q[CW-1]}}, cx_q};
  assign cy_ext  = {{COORD_W{cy_q[CW-1]}}, cy_q};

  always_ff @(posedge clk_i) begin
    if (take_place) begin
      h_q    <= hash_q;
      hmod_q <= '0;
      dig_q  <= '0;
      par_q  <= IDX_W'(cnt_q - CNT_W'(1));
      cx_q   <= '0;
      cy_q   <= '0;
    end
    if (cmd_i.mod_step) begin
      hmod_q <= mod6_step(hmod_q, nib);
      dig_q  <= dig_q + DIG_CNT_W'(1);
    end
    if (cmd_i.par_ld) begin
      px_q   <= rd_q[2*CW-1:CW];
      py_q   <= rd_q[CW-1:0];
      esum_q <= h_q;
      eres_q <= hmod_q;
      ecnt_q <= '0;
    end
    if (cmd_i.cand_ld) begin
      cx_q   <= nx;
      cy_q   <= ny;
      scan_q <= '0;
    end
    if (issue) begin
      scan_q <= scan_q + CNT_W'(1);
    end
    if (cmd_i.next_edge) begin
      esum_q <= esum_q + HASH_W'(1);
      ecnt_q <= ecnt_q + EDGE_W'(1);
      if (esum_q == '1 || eres_q == EDGE_W'(NUM_EDGES - 1)) begin
        eres_q <= '0;
      end else begin
        eres_q <= eres_q + EDGE_W'(1);
      end
    end
    if (cmd_i.next_par) begin
      par_q <= par_q - IDX_W'(1);
    end
    if (cmd_i.finish) begin
      idx_q    <= fail_q ? '0 : cnt_ext[INDEX_W-1:0];
      x_q      <= fail_q ? '0 : cx_ext[COORD_W-1:0];
      y_q      <= fail_q ? '0 : cy_ext[COORD_W-1:0];
      status_q <= fail_q ? STATUS_FULL : STATUS_PLACED;
    end
  end

  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.full      = (cnt_q == CNT_W'(MAX_TILES));
  assign sts_o.mod_last  = (dig_q == DIG_CNT_W'(NUM_DIGITS - 1));
  assign sts_o.hit       = hit;
  assign sts_o.free      = !hit && scan_end && !rd_vld_q;
  assign sts_o.edge_last = (ecnt_q == EDGE_W'(NUM_EDGES - 1));
  assign sts_o.par_zero  = (par_q == '0);
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign tile_index_o = idx_q;
  assign tile_x_o     = x_q;
  assign tile_y_o     = y_q;
  assign status_o     = status_q;

endmodule

/* hw/rtl/htp_ctrl.sv */
// ----------------------------------------------------------------------------
// Hex tile placement controller
// Sequences the hash residue, the walk over earlier tiles and the result.
// ----------------------------------------------------------------------------
module htp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [htp_pkg::MODE_W-1:0] in_mode_i,
  output logic                       in_ready_o,
  input  htp_pkg::sts_t              sts_i,
  output htp_pkg::cmd_t              cmd_o
);
  import htp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_mode_i == MODE_PLACE) begin
            state_d = (sts_i.cnt_zero || sts_i.full) ? ST_DONE : ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = ST_PRD;
        end
      end
      ST_PRD: begin
        cmd_o.par_rd = 1'b1;
        state_d      = ST_PLD;
      end
      ST_PLD: begin
        cmd_o.par_ld = 1'b1;
        state_d      = ST_CAND;
      end
      ST_CAND: begin
        cmd_o.cand_ld = 1'b1;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          if (!sts_i.edge_last) begin
            cmd_o.next_edge = 1'b1;
            state_d         = ST_CAND;
          end else if (sts_i.par_zero) begin
            cmd_o.set_fail = 1'b1;
            state_d        = ST_DONE;
          end else begin
            cmd_o.next_par = 1'b1;
            state_d        = ST_PRD;
          end
        end else if (sts_i.free) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/hex_tile_placement.sv */
// ----------------------------------------------------------------------------
// Hex tile placement
// Builds a name hash and places hexagon tiles on an offset-row hex grid.
// ----------------------------------------------------------------------------
// Name-byte and clear requests are taken in the idle state. A place request
// for the first tile or a full table goes straight to the result; otherwise it
// is accepted, the hash is reduced modulo six one digit at a time, and then
// each earlier tile visited, newest first, is fetched (read, then load) and,
// per edge tried, a candidate cell is formed and the stored tiles are scanned
// until an occupied cell is hit or all are found free; the result is then
// loaded. The final step waits while the previous result has not been taken.
// The search is bound by the tile store's single read port, which the occupancy
// scan walks one stored tile per cycle. Name bytes are accepted while a result
// still waits in the output register.
module hex_tile_placement #(
  parameter int unsigned MAX_TILES = htp_pkg::MAX_TILES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htp_in_if.sink     in_i,
  htp_out_if.source  out_o
);
  import htp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  htp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htp_datapath #(
    .MAX_TILES (MAX_TILES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (in_i.mode),
    .name_byte_i  (in_i.name_byte),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .tile_index_o (out_o.tile_index),
    .tile_x_o     (out_o.tile_x),
    .tile_y_o     (out_o.tile_y),
    .status_o     (out_o.status)
  );

  a_place_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.mode == MODE_PLACE) |=> !in_i.ready)
    else $error("Block did not go busy after a place request.");

  a_hit_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.hit |-> cmd.scan)
    else $error("Occupancy hit reported outside of a scan.");

  a_finish_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_o.valid || out_o.ready))
    else $error("Result loaded over one that was not taken.");

  a_finish_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_o.valid)
    else $error("Finished placement did not raise the output valid.");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hex tile placement testbench
// Sends name-byte, place and clear requests with random gaps and checks each
// placement result against a predictor of the hash and of the hex grid
// search. Runs a directed part, one layout filled to capacity and then past
// it, and a random part of short names and small layouts.
// ----------------------------------------------------------------------------
module tb_top;
  import htp_pkg::*;

  localparam int unsigned TILE_CAP       = MAX_TILES_DEF;
  localparam int unsigned TARGET_REQS    = 1750;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES    = 200;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] name_byte;
    int unsigned       gap;
    bit                drain;
  } tile_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        tile_index;
    logic signed [COORD_W-1:0] tile_x;
    logic signed [COORD_W-1:0] tile_y;
    logic                      status;
  } tile_result_t;

  logic clk_i;
  logic rst_ni;

  htp_in_if  req_if ();
  htp_out_if res_if ();

  hex_tile_placement #(
    .MAX_TILES(TILE_CAP)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  tile_req_t    req_q[$];
  tile_result_t tile_q[$];
  tile_req_t    cur_req;

  bit [HASH_W-1:0] name_hash;
  int unsigned     tile_count;
  int              tile_col[TILE_CAP];
  int              tile_row[TILE_CAP];

  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned results_due;
  int unsigned results_seen;
  int unsigned reqs_done;
  int unsigned n_reqs;
  int unsigned idle_cycles;
  int unsigned fail_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_wait(input int unsigned n, input int unsigned span);
    if ((n / span) % 4 == 3) return 0;
    return $urandom_range(16, 0);
  endfunction

  function automatic void hex_step(input int x, input int y, input edge_e dir,
                                   output int nx, output int ny);
    bit odd;
    odd = y[0];
    case (dir)
      EDGE_E:    begin nx = x + 1;              ny = y;     end
      EDGE_NE:   begin nx = odd ? x + 1 : x;    ny = y - 1; end
      EDGE_NW:   begin nx = odd ? x : x - 1;    ny = y - 1; end
      EDGE_WEST: begin nx = x - 1;              ny = y;     end
      EDGE_SW:   begin nx = odd ? x : x - 1;    ny = y + 1; end
      default:   begin nx = odd ? x + 1 : x;    ny = y + 1; end
    endcase
  endfunction

  function automatic bit cell_taken(input int x, input int y);
    for (int i = 0; i < tile_count; i++) begin
      if (tile_col[i] == x && tile_row[i] == y) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic apply_request(input tile_req_t rq);
    tile_result_t    r;
    bit [HASH_W-1:0] h;
    bit [HASH_W-1:0] sum;
    int              nx;
    int              ny;
    bit              found;
    nx = 0;
    ny = 0;
    found = 1'b0;
    case (rq.mode)
      MODE_BYTE: begin
        if (rq.name_byte != '0) name_hash = name_hash * HASH_MUL + HASH_W'(rq.name_byte);
      end
      MODE_CLEAR: begin
        name_hash = '0;
        tile_count = 0;
      end
      MODE_PLACE: begin
        h = name_hash;
        name_hash = '0;
        if (tile_count >= TILE_CAP) begin
          found = 1'b0;
        end else if (tile_count == 0) begin
          found = 1'b1;
        end else begin
          for (int p = tile_count; p > 0 && !found; p--) begin
            for (int e = 0; e < NUM_EDGES && !found; e++) begin
              sum = h + HASH_W'(e);
              hex_step(tile_col[p-1], tile_row[p-1], edge_e'(EDGE_W'(sum % NUM_EDGES)), nx, ny);
              found = !cell_taken(nx, ny);
            end
          end
        end
        if (found) begin
          r.tile_index = tile_count[INDEX_W-1:0];
          r.tile_x = nx[COORD_W-1:0];
          r.tile_y = ny[COORD_W-1:0];
          r.status = STATUS_PLACED;
          tile_col[tile_count] = nx;
          tile_row[tile_count] = ny;
          tile_count++;
        end else begin
          r = '0;
          r.status = STATUS_FULL;
        end
        tile_q.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    bit          accept;
    int unsigned due_now;
    int unsigned gap;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.mode <= MODE_BYTE;
      req_if.name_byte <= '0;
      gap_left <= 0;
      results_due <= 0;
      reqs_done <= 0;
    end else begin
      accept = req_if.valid && req_if.ready;
      due_now = results_due;
      gap = gap_left;
      if (accept) begin
        apply_request(cur_req);
        if (cur_req.mode == MODE_PLACE) due_now++;
        results_due <= due_now;
        reqs_done <= reqs_done + 1;
        gap = (req_q.size() != 0) ? req_q[0].gap : 0;
      end
      if (req_if.valid && !accept) begin
      end else if (gap != 0) begin
        gap_left <= gap - 1;
        req_if.valid <= 1'b0;
      end else if (req_q.size() != 0 && (!req_q[0].drain || due_now == results_seen)) begin
        cur_req = req_q.pop_front();
        req_if.mode <= cur_req.mode;
        req_if.name_byte <= cur_req.name_byte;
        req_if.valid <= 1'b1;
        gap_left <= 0;
      end else begin
        req_if.valid <= 1'b0;
        gap_left <= 0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : tile_monitor
    tile_result_t got;
    tile_result_t want;
    int unsigned  w;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
      results_seen <= 0;
    end else if (res_if.valid && res_if.ready) begin
      got.tile_index = res_if.tile_index;
      got.tile_x = res_if.tile_x;
      got.tile_y = res_if.tile_y;
      got.status = res_if.status;
      if (tile_q.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result: idx=%0d x=%0d y=%0d status=%0d",
                   got.tile_index, got.tile_x, got.tile_y, got.status);
        end
        fail_count++;
      end else begin
        want = tile_q.pop_front();
        if (got.tile_index !== want.tile_index || got.tile_x !== want.tile_x ||
            got.tile_y !== want.tile_y || got.status !== want.status) begin
          if (fail_count < 10) begin
            $display({"result %0d: expected idx=%0d x=%0d y=%0d status=%0d,",
                      " got idx=%0d x=%0d y=%0d status=%0d"},
                     results_seen, want.tile_index, want.tile_x, want.tile_y, want.status,
                     got.tile_index, got.tile_x, got.tile_y, got.status);
          end
          fail_count++;
        end
      end
      results_seen <= results_seen + 1;
      w = draw_wait(results_seen, 40);
      stall_left <= w;
      res_if.ready <= (w == 0);
    end else if (stall_left != 0) begin
      if (res_if.valid) stall_left <= stall_left - 1;
      res_if.ready <= res_if.valid && stall_left == 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_req(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] b,
                         input bit drain = 1'b0);
    tile_req_t rq;
    rq.mode = mode;
    rq.name_byte = b;
    rq.gap = draw_wait(req_q.size(), 150);
    rq.drain = drain;
    req_q.push_back(rq);
  endtask

  task automatic add_name(input int unsigned len);
    for (int i = 0; i < len; i++) add_req(MODE_BYTE, BYTE_W'($urandom_range(255, 1)));
  endtask

  initial begin
    int unsigned counted;
    int unsigned pick;
    int unsigned len;
    bit          leftover;
    req_if.valid = 1'b0;
    req_if.mode = MODE_BYTE;
    req_if.name_byte = '0;
    res_if.ready = 1'b0;
    rst_ni = 1'b0;
    name_hash = '0;
    tile_count = 0;
    fail_count = 0;

    // Directed part: origin, first edges other than east, zero bytes, unused mode, wrap.
    add_req(MODE_NONE, 8'h5A);
    add_req(MODE_PLACE, 8'h00);
    add_req(MODE_BYTE, 8'h00);
    add_req(MODE_BYTE, 8'h01);
    add_req(MODE_PLACE, 8'hFF);
    add_req(MODE_BYTE, 8'hFF);
    add_req(MODE_PLACE, 8'h00);
    add_req(MODE_BYTE, 8'h02);
    add_req(MODE_PLACE, 8'h00);
    add_req(MODE_BYTE, 8'h04);
    add_req(MODE_PLACE, 8'h00);
    add_req(MODE_BYTE, 8'h05);
    add_req(MODE_PLACE, 8'h00);
    add_req(MODE_BYTE, 8'h03);
    add_req(MODE_PLACE, 8'h00);
    for (int i = 0; i < 7; i++) add_req(MODE_BYTE, 8'hFF);
    add_req(MODE_PLACE, 8'h00);
    add_req(MODE_BYTE, 8'h80);
    add_req(MODE_CLEAR, 8'h00, 1'b1);
    add_req(MODE_PLACE, 8'h00);
    counted = req_q.size();

    // One layout filled to capacity, then place requests against the full table.
    add_req(MODE_CLEAR, 8'h00, 1'b1);
    counted++;
    for (int i = 0; i < TILE_CAP + 3; i++) begin
      if ($urandom_range(15, 0) == 0) begin
        add_name(1);
        counted++;
      end
      add_req(MODE_PLACE, 8'h00);
      counted++;
    end
    add_req(MODE_NONE, BYTE_W'($urandom_range(255, 0)));
    add_req(MODE_BYTE, 8'h00);
    add_name(3);
    add_req(MODE_PLACE, 8'h00);
    add_req(MODE_CLEAR, 8'h00);
    counted += 5;

    // Random names and small layouts, with some noise and broken names.
    while (counted < TARGET_REQS) begin
      pick = $urandom_range(99, 0);
      if (pick < 3) begin
        add_req(MODE_CLEAR, BYTE_W'($urandom_range(255, 0)), $urandom_range(9, 0) == 0);
        counted++;
      end else if (pick < 83) begin
        len = $urandom_range(6, 0);
        add_name(len);
        add_req(MODE_PLACE, BYTE_W'($urandom_range(255, 0)));
        counted += len + 1;
      end else if (pick < 89) begin
        add_req(MODE_NONE, BYTE_W'($urandom_range(255, 0)));
      end else if (pick < 93) begin
        add_req(MODE_BYTE, 8'h00);
      end else if (pick < 97) begin
        len = $urandom_range(4, 1);
        add_name(len);
        add_req(MODE_CLEAR, BYTE_W'($urandom_range(255, 0)));
        counted += len + 1;
      end else begin
        add_name(2);
        add_req(MODE_BYTE, 8'h00);
        add_name(2);
        add_req(MODE_PLACE, 8'h00);
        counted += 5;
      end
    end
    n_reqs = req_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(reqs_done == n_reqs && results_seen == results_due) &&
           idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
    end
    if (idle_cycles < WATCHDOG_LIMIT) repeat (TAIL_CYCLES) @(posedge clk_i);
    leftover = (results_due != results_seen);
    if (leftover) $display("%0d placement results never arrived", results_due - results_seen);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hex_tile_placement: mismatch");
    end else if (fail_count == 0 && !leftover) begin
      $display("hex_tile_placement: match");
    end else begin
      $display("hex_tile_placement: mismatch");
    end
    $finish;
  end

endmodule
